// ----- design/nsbe_pkg.sv -----
// Shared types and constants for the NSEC type bitmap encoder.
package nsbe_pkg;

	localparam int WIN_BYTES  = 32;
	localparam int ROW_BITS   = WIN_BYTES * 8;
	localparam int LEN_W      = 6;
	localparam int SIZE_W     = 14;
	localparam int CURSOR_W   = 9;
	localparam int SCAN_LANES = 8;
	localparam int MAX_SIZE   = 8704;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_CLEAR  = 2'd1,
		KIND_READ   = 2'd2,
		KIND_REWIND = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] rr_type;
	} item_t;

	typedef struct packed {
		logic [7:0]        out_byte;
		logic              end_of_window;
		logic              end_of_bitmap;
		logic [SIZE_W-1:0] total_size;
	} result_t;

	// classified command handed from front to back
	typedef struct packed {
		kind_t      kind;
		logic [7:0] win;
		logic [4:0] byte_idx;
		logic [2:0] bit_idx;
	} cmd_t;

	// one memory row: used length plus the window's bitmap, byte b at bits [8b+7:8b]
	typedef struct packed {
		logic [LEN_W-1:0]    len;
		logic [ROW_BITS-1:0] bits;
	} row_t;

endpackage

// ----- design/nsbe_front.sv -----
// Front end: takes items and classifies them into back-end commands.
module nsbe_front
	import nsbe_pkg::*;
#(
	parameter int WINDOW_COUNT = 256
) (
	input  logic  item_valid,
	input  item_t item,
	output logic  item_stall,
	input  logic  q_full,
	output logic  q_push,
	output cmd_t  q_cmd
);

	logic drop;

	// an add past the last window has no effect at all
	assign drop = (item.kind == KIND_ADD) && (32'(item.rr_type[15:8]) >= WINDOW_COUNT);

	assign item_stall = q_full;
	assign q_push     = item_valid && !q_full && !drop;

	always_comb begin
		q_cmd.kind     = item.kind;
		q_cmd.win      = item.rr_type[15:8];
		q_cmd.byte_idx = item.rr_type[7:3];
		q_cmd.bit_idx  = item.rr_type[2:0];
	end

endmodule

// ----- design/nsbe_queue.sv -----
// Two-entry command queue between front and back end.
module nsbe_queue
	import nsbe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ----- design/nsbe_back.sv -----
// Back end: window memory, add read-modify-write, window scan and byte streaming.
module nsbe_back
	import nsbe_pkg::*;
#(
	parameter int WINDOW_COUNT = 256
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    head_valid,
	input  cmd_t    head,
	output logic    pop,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int AW = (WINDOW_COUNT > 1) ? $clog2(WINDOW_COUNT) : 1;

	typedef enum logic [8:0] {
		ST_IDLE      = 9'b000000001,
		ST_ADD_WR    = 9'b000000010,
		ST_SCAN      = 9'b000000100,
		ST_LOAD      = 9'b000001000,
		ST_EMIT_WIN  = 9'b000010000,
		ST_EMIT_LEN  = 9'b000100000,
		ST_EMIT_DATA = 9'b001000000,
		ST_EMIT_END  = 9'b010000000,
		ST_REWIND    = 9'b100000000
	} state_t;

	state_t                state_q;
	logic [CURSOR_W-1:0]   cursor_q;
	logic [CURSOR_W-1:0]   scan_q;
	logic [SIZE_W-1:0]     size_q;
	logic [WINDOW_COUNT-1:0] nonempty_q;
	logic [LEN_W-1:0]      cnt_q;
	cmd_t                  cmd_q;
	logic [7:0]            win_q;
	logic [LEN_W-1:0]      len_q;
	logic [ROW_BITS-1:0]   row_q;
	result_t               res_q;
	logic                  res_valid_q;

	row_t                  row_mem_q [WINDOW_COUNT];
	row_t                  rd_q;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	row_t                  wr_data;

	// scan
	logic [SCAN_LANES-1:0] hit;
	logic [CURSOR_W:0]     lane_idx [SCAN_LANES];
	logic [2:0]            found_off;
	logic [CURSOR_W-1:0]   found_idx;
	logic [CURSOR_W:0]     scan_next;
	logic                  scan_last;

	// add
	logic                  was_used;
	logic [LEN_W-1:0]      old_len;
	logic [ROW_BITS-1:0]   new_row;
	logic [7:0]            bit_pos;
	logic                  grow;
	logic [LEN_W-1:0]      new_len;
	logic [SIZE_W-1:0]     size_add;

	// output
	logic                  slot_free;
	logic                  emitting;
	logic                  load_res;
	logic                  data_last;
	result_t               res_next;

	assign pop = (state_q == ST_IDLE) && head_valid;

	always_comb begin
		for (int i = 0; i < SCAN_LANES; i++) begin
			lane_idx[i] = {1'b0, scan_q} + (CURSOR_W+1)'(i);
			hit[i] = (32'(lane_idx[i]) < WINDOW_COUNT) && nonempty_q[lane_idx[i][AW-1:0]];
		end
		found_off = '0;
		for (int i = SCAN_LANES - 1; i >= 0; i--) begin
			if (hit[i]) found_off = 3'(i);
		end
	end

	assign found_idx = scan_q + CURSOR_W'(found_off);
	assign scan_next = {1'b0, scan_q} + (CURSOR_W+1)'(SCAN_LANES);
	assign scan_last = (32'(scan_next) >= WINDOW_COUNT);

	// a row whose window is not marked used holds stale data and reads as empty
	always_comb begin
		was_used = nonempty_q[cmd_q.win[AW-1:0]];
		old_len  = was_used ? rd_q.len : '0;
		new_row  = was_used ? rd_q.bits : '0;
		bit_pos  = {cmd_q.byte_idx, ~cmd_q.bit_idx};
		new_row[bit_pos] = 1'b1;
		grow     = (old_len <= {1'b0, cmd_q.byte_idx});
		new_len  = grow ? ({1'b0, cmd_q.byte_idx} + LEN_W'(1)) : old_len;
		size_add = size_q + SIZE_W'(cmd_q.byte_idx) + SIZE_W'(1)
			+ ((old_len == '0) ? SIZE_W'(2) : SIZE_W'(0)) - SIZE_W'(old_len);
	end

	assign rd_en   = (pop && (head.kind == KIND_ADD)) || ((state_q == ST_SCAN) && (|hit));
	assign rd_addr = (state_q == ST_SCAN) ? found_idx[AW-1:0] : head.win[AW-1:0];
	assign wr_en   = (state_q == ST_ADD_WR);
	assign wr_data = '{len: new_len, bits: new_row};

	always_ff @(posedge clk) begin
		if (wr_en) row_mem_q[cmd_q.win[AW-1:0]] <= wr_data;
		if (rd_en) rd_q <= row_mem_q[rd_addr];
	end

	assign slot_free = !res_valid_q || !result_stall;
	assign emitting  = (state_q == ST_EMIT_WIN) || (state_q == ST_EMIT_LEN)
		|| (state_q == ST_EMIT_DATA) || (state_q == ST_EMIT_END) || (state_q == ST_REWIND);
	assign load_res  = emitting && slot_free;
	assign data_last = ((cnt_q + LEN_W'(1)) == len_q);

	always_comb begin
		res_next.out_byte      = '0;
		res_next.end_of_window = 1'b0;
		res_next.end_of_bitmap = 1'b0;
		res_next.total_size    = size_q;
		case (state_q)
			ST_EMIT_WIN:  res_next.out_byte = win_q;
			ST_EMIT_LEN:  res_next.out_byte = 8'(len_q);
			ST_EMIT_DATA: begin
				res_next.out_byte      = row_q[7:0];
				res_next.end_of_window = data_last;
			end
			ST_EMIT_END: begin
				res_next.end_of_window = 1'b1;
				res_next.end_of_bitmap = 1'b1;
			end
			ST_REWIND:    res_next.end_of_window = 1'b1;
			default:      res_next.out_byte = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cursor_q    <= '0;
			scan_q      <= '0;
			size_q      <= '0;
			nonempty_q  <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_res) res_valid_q <= 1'b1;
			else if (!result_stall) res_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						unique case (head.kind)
							KIND_ADD: state_q <= ST_ADD_WR;
							KIND_CLEAR: begin
								nonempty_q <= '0;
								size_q     <= '0;
								cursor_q   <= '0;
							end
							KIND_READ: begin
								scan_q  <= cursor_q;
								state_q <= ST_SCAN;
							end
							KIND_REWIND: begin
								cursor_q <= '0;
								state_q  <= ST_REWIND;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ADD_WR: begin
					nonempty_q[cmd_q.win[AW-1:0]] <= 1'b1;
					if (grow) size_q <= size_add;
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (|hit) begin
						cursor_q <= found_idx + CURSOR_W'(1);
						state_q  <= ST_LOAD;
					end else if (scan_last) begin
						cursor_q <= CURSOR_W'(WINDOW_COUNT);
						state_q  <= ST_EMIT_END;
					end else begin
						scan_q <= scan_next[CURSOR_W-1:0];
					end
				end
				ST_LOAD: state_q <= ST_EMIT_WIN;
				ST_EMIT_WIN: begin
					if (slot_free) state_q <= ST_EMIT_LEN;
				end
				ST_EMIT_LEN: begin
					if (slot_free) begin
						cnt_q   <= '0;
						state_q <= ST_EMIT_DATA;
					end
				end
				ST_EMIT_DATA: begin
					if (slot_free) begin
						cnt_q <= cnt_q + LEN_W'(1);
						if (data_last) state_q <= ST_IDLE;
					end
				end
				ST_EMIT_END, ST_REWIND: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= head;
		if ((state_q == ST_SCAN) && (|hit)) win_q <= found_idx[7:0];
		if (state_q == ST_LOAD) begin
			row_q <= rd_q.bits;
			len_q <= rd_q.len;
		end else if ((state_q == ST_EMIT_DATA) && slot_free) begin
			row_q <= row_q >> 8;
		end
		if (load_res) res_q <= res_next;
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// ----- design/nsec_type_bitmap_encoder_top.sv -----
// Top level of the NSEC type bitmap encoder: front end, command queue, back end.
// Add: row read, then modify and write in the back end; rewind: an end-of-window item.
// Read: pop, scan eight windows per step, load the found row, then emit 2 + length bytes
//   at one per cycle from the output register unless stalled, or an end-of-bitmap item.
// The front end and queue take a new item each cycle while the two-entry queue has room.
// Reset clears control state and the per-window used flags; row memory is never swept,
//   rows of unused windows read as empty.
module nsec_type_bitmap_encoder_top
	import nsbe_pkg::*;
#(
	parameter int WINDOW_COUNT = 256
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic q_full;
	logic q_push;
	cmd_t q_cmd;
	logic head_valid;
	cmd_t head;
	logic pop;

	nsbe_front #(.WINDOW_COUNT(WINDOW_COUNT)) u_front (
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_cmd)
	);

	nsbe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	nsbe_back #(.WINDOW_COUNT(WINDOW_COUNT)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ----- design/nsbe_checker.sv -----
// Port-level checks for the NSEC type bitmap encoder, bound to the top level.
module nsbe_checker
	import nsbe_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// end of bitmap is a lone zero item that closes the read
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.end_of_bitmap |->
			result.end_of_window && (result.out_byte == 8'd0))
		else $error("bad end-of-bitmap item");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (32'(result.total_size) <= MAX_SIZE))
		else $error("encoded size out of range");

	// inside a window stream the next item can never be end of bitmap
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !result.end_of_window |=>
			!result_valid || !result.end_of_bitmap)
		else $error("end of bitmap inside a window");

endmodule

bind nsec_type_bitmap_encoder_top nsbe_checker u_nsbe_checker (.*);
